// ===== hw/rtl/rpbe_pkg.sv =====
// Shared constants, codes and control types of the RGB pixel buffer engine.
`timescale 1ns / 1ps
package rpbe_pkg;

    localparam int PIXEL_COUNT_DEF = 64;
    localparam int MAX_PIXELS      = 256;
    localparam int CHAN_W          = 8;
    localparam int PIXEL_W         = 3 * CHAN_W;
    localparam int INDEX_W         = 8;
    localparam int CMD_W           = 3;
    localparam int PCT_W           = 7;
    localparam int PROD_W          = CHAN_W + PCT_W;
    localparam int SCALE_W         = 2 * PROD_W;

    localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);

    // floor(x / 100) == (x * DIV100_MUL) >> DIV100_SHIFT for every x below 43690
    localparam logic [PROD_W-1:0] DIV100_MUL   = PROD_W'(20972);
    localparam int                DIV100_SHIFT = 21;

    localparam logic [CMD_W-1:0] CMD_SET   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_GET   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_OR    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_XOR   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DIM   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd5;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCALE
    } state_t;

    typedef struct packed {
        logic load;
        logic scale;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_scale;
        logic out_free;
    } dp_status_t;

endpackage

// ===== hw/rtl/rpbe_cmd_if.sv =====
// Command channel: valid/ready handshake with one command item as payload.
`timescale 1ns / 1ps
interface rpbe_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] command;
    logic [7:0] pixel_index;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] dim_percent;

    modport source (
        output valid, command, pixel_index, red_in, green_in, blue_in, dim_percent,
        input  ready
    );

    modport sink (
        input  valid, command, pixel_index, red_in, green_in, blue_in, dim_percent,
        output ready
    );
endinterface

// ===== hw/rtl/rpbe_rsp_if.sv =====
// Response channel: valid/ready handshake with one result item as payload.
`timescale 1ns / 1ps
interface rpbe_rsp_if;
    logic       valid;
    logic       ready;
    logic       status;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;

    modport source (
        output valid, status, red_out, green_out, blue_out,
        input  ready
    );

    modport sink (
        input  valid, status, red_out, green_out, blue_out,
        output ready
    );
endinterface

// ===== hw/rtl/rgb_pixel_buffer_engine_top.sv =====
// Top level of the RGB pixel buffer engine: controller, datapath and checks.
//
//  channel | role | payload
//  --------+------+-------------------------------------------------------------
//  cmd     | in   | command, pixel_index, red_in, green_in, blue_in, dim_percent
//  rsp     | out  | status, red_out, green_out, blue_out
//
// One item at a time. Get, set, OR, XOR, clear-all, range errors and unknown codes
// read memory at the accepting edge, then in ST_EXEC write back and load the result
// at commit. Dim first registers the channel-by-percent product in ST_EXEC and commits
// from ST_SCALE. Clear-all drops the per-pixel valid bits at once; reset does the same.
// A new item is accepted while the previous result waits; a stalled rsp holds
// the next commit until the result register frees.
`timescale 1ns / 1ps
module rgb_pixel_buffer_engine_top #(
    parameter int PIXEL_COUNT = rpbe_pkg::PIXEL_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    rpbe_cmd_if.sink    cmd,
    rpbe_rsp_if.source  rsp
);
    import rpbe_pkg::*;

    ctrl_cmd_t  ctrl_cmd;
    dp_status_t dp_status;

    rpbe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .dp_status (dp_status),
        .ctrl_cmd  (ctrl_cmd)
    );

    rpbe_datapath #(
        .PIXEL_COUNT (PIXEL_COUNT)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl_cmd    (ctrl_cmd),
        .dp_status   (dp_status),
        .command     (cmd.command),
        .pixel_index (cmd.pixel_index),
        .red_in      (cmd.red_in),
        .green_in    (cmd.green_in),
        .blue_in     (cmd.blue_in),
        .dim_percent (cmd.dim_percent),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .status      (rsp.status),
        .red_out     (rsp.red_out),
        .green_out   (rsp.green_out),
        .blue_out    (rsp.blue_out)
    );

    a_one_item_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> !cmd.ready)
        else $error("item accepted while another is in flight");

    a_single_phase: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctrl_cmd.load, ctrl_cmd.scale, ctrl_cmd.commit}))
        else $error("more than one control phase active");

    a_scale_then_no_load: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.scale |=> !ctrl_cmd.load && !cmd.ready)
        else $error("new item taken during dim scaling");

    a_commit_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.commit |=> rsp.valid)
        else $error("commit did not present a result");

endmodule

// ===== hw/rtl/rpbe_ctrl.sv =====
// Controller state machine sequencing load, scale and commit of one command item.
`timescale 1ns / 1ps
module rpbe_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  rpbe_pkg::dp_status_t   dp_status,
    output rpbe_pkg::ctrl_cmd_t    ctrl_cmd
);
    import rpbe_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (dp_status.need_scale)
                begin
                    state_next = ST_SCALE;
                end
                else if (dp_status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCALE:
            begin
                if (dp_status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready        = 1'b0;
        ctrl_cmd.load   = 1'b0;
        ctrl_cmd.scale  = 1'b0;
        ctrl_cmd.commit = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                ctrl_cmd.load = in_valid;
            end
            ST_EXEC:
            begin
                ctrl_cmd.scale  = dp_status.need_scale;
                ctrl_cmd.commit = !dp_status.need_scale && dp_status.out_free;
            end
            ST_SCALE:
            begin
                ctrl_cmd.commit = dp_status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/rpbe_datapath.sv =====
// Datapath: pixel memory, valid bits, channel arithmetic and result register.
`timescale 1ns / 1ps
module rpbe_datapath #(
    parameter int PIXEL_COUNT = rpbe_pkg::PIXEL_COUNT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rpbe_pkg::ctrl_cmd_t           ctrl_cmd,
    output rpbe_pkg::dp_status_t          dp_status,
    input  logic [rpbe_pkg::CMD_W-1:0]    command,
    input  logic [rpbe_pkg::INDEX_W-1:0]  pixel_index,
    input  logic [rpbe_pkg::CHAN_W-1:0]   red_in,
    input  logic [rpbe_pkg::CHAN_W-1:0]   green_in,
    input  logic [rpbe_pkg::CHAN_W-1:0]   blue_in,
    input  logic [rpbe_pkg::CHAN_W-1:0]   dim_percent,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          status,
    output logic [rpbe_pkg::CHAN_W-1:0]   red_out,
    output logic [rpbe_pkg::CHAN_W-1:0]   green_out,
    output logic [rpbe_pkg::CHAN_W-1:0]   blue_out
);
    import rpbe_pkg::*;

    localparam int AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

    logic [PIXEL_W-1:0]     mem [PIXEL_COUNT];
    logic [PIXEL_COUNT-1:0] valid_reg;
    logic [PIXEL_COUNT-1:0] valid_next;

    logic [CMD_W-1:0]  op_reg;
    logic [AW-1:0]     addr_reg;
    logic              in_range_reg;
    logic              hit_reg;
    logic [CHAN_W-1:0] red_op_reg;
    logic [CHAN_W-1:0] green_op_reg;
    logic [CHAN_W-1:0] blue_op_reg;
    logic [PCT_W-1:0]  keep_reg;
    logic [PIXEL_W-1:0] mem_q_reg;
    logic [PROD_W-1:0] prod_r_reg;
    logic [PROD_W-1:0] prod_g_reg;
    logic [PROD_W-1:0] prod_b_reg;

    logic              out_valid_reg;
    logic              status_reg;
    logic [CHAN_W-1:0] red_out_reg;
    logic [CHAN_W-1:0] green_out_reg;
    logic [CHAN_W-1:0] blue_out_reg;

    logic              in_range;
    logic [AW-1:0]     addr;
    logic [PCT_W-1:0]  keep;
    logic [PIXEL_W-1:0] pix;
    logic [CHAN_W-1:0] pix_r;
    logic [CHAN_W-1:0] pix_g;
    logic [CHAN_W-1:0] pix_b;
    logic [SCALE_W-1:0] scl_r;
    logic [SCALE_W-1:0] scl_g;
    logic [SCALE_W-1:0] scl_b;
    logic [PIXEL_W-1:0] wdata;
    logic              wr_en;
    logic              is_get;

    assign in_range = ({1'b0, pixel_index} < (INDEX_W + 1)'(PIXEL_COUNT));
    assign addr     = pixel_index[AW-1:0];
    assign keep     = (dim_percent > CHAN_W'(PCT_FULL)) ? '0
                      : PCT_FULL - dim_percent[PCT_W-1:0];

    assign pix   = hit_reg ? mem_q_reg : '0;
    assign pix_g = pix[2*CHAN_W +: CHAN_W];
    assign pix_r = pix[CHAN_W +: CHAN_W];
    assign pix_b = pix[0 +: CHAN_W];

    assign scl_r = SCALE_W'(prod_r_reg) * SCALE_W'(DIV100_MUL);
    assign scl_g = SCALE_W'(prod_g_reg) * SCALE_W'(DIV100_MUL);
    assign scl_b = SCALE_W'(prod_b_reg) * SCALE_W'(DIV100_MUL);

    assign is_get = (op_reg == CMD_GET) && in_range_reg;

    always_comb
    begin
        wr_en = in_range_reg;
        wdata = pix;
        unique case (op_reg)
            CMD_SET:
            begin
                wdata = {green_op_reg, red_op_reg, blue_op_reg};
            end
            CMD_OR:
            begin
                wdata = pix | {green_op_reg, red_op_reg, blue_op_reg};
            end
            CMD_XOR:
            begin
                wdata = pix ^ {green_op_reg, red_op_reg, blue_op_reg};
            end
            CMD_DIM:
            begin
                wdata = {scl_g[DIV100_SHIFT +: CHAN_W], scl_r[DIV100_SHIFT +: CHAN_W],
                         scl_b[DIV100_SHIFT +: CHAN_W]};
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (ctrl_cmd.commit && (op_reg == CMD_CLEAR))
        begin
            valid_next = '0;
        end
        else if (ctrl_cmd.commit && wr_en)
        begin
            valid_next[addr_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_cmd.load && in_range)
        begin
            mem_q_reg <= mem[addr];
        end
        if (ctrl_cmd.commit && wr_en)
        begin
            mem[addr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (ctrl_cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_cmd.load)
        begin
            op_reg       <= command;
            addr_reg     <= addr;
            in_range_reg <= in_range;
            hit_reg      <= in_range && valid_reg[addr];
            red_op_reg   <= red_in;
            green_op_reg <= green_in;
            blue_op_reg  <= blue_in;
            keep_reg     <= keep;
        end
        if (ctrl_cmd.scale)
        begin
            prod_r_reg <= PROD_W'(pix_r) * PROD_W'(keep_reg);
            prod_g_reg <= PROD_W'(pix_g) * PROD_W'(keep_reg);
            prod_b_reg <= PROD_W'(pix_b) * PROD_W'(keep_reg);
        end
        if (ctrl_cmd.commit)
        begin
            status_reg    <= (!in_range_reg && (op_reg <= CMD_DIM)) ? STATUS_RANGE
                             : STATUS_OK;
            red_out_reg   <= is_get ? pix_r : '0;
            green_out_reg <= is_get ? pix_g : '0;
            blue_out_reg  <= is_get ? pix_b : '0;
        end
    end

    assign dp_status.need_scale = (op_reg == CMD_DIM) && in_range_reg;
    assign dp_status.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign red_out   = red_out_reg;
    assign green_out = green_out_reg;
    assign blue_out  = blue_out_reg;

endmodule
